### rtl/bcc_pkg.sv
// Shared types and constants for the block claim checker.
// Depends on nothing; every other file imports it.
package bcc_pkg;

  typedef enum logic [1:0] {
    CMD_NEW_INODE = 2'd0,
    CMD_CLAIM     = 2'd1,
    CMD_RESCAN    = 2'd2,
    CMD_RELEASE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_SKIP     = 2'd1,
    ST_STOP     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_FIRST_GROUP  = 3'd0,
    REG_GROUP_SIZE   = 3'd1,
    REG_GROUP_INODES = 3'd2,
    REG_GROUP_COUNT  = 3'd3,
    REG_VOLUME       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] block;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        dup_found;
    logic        bad_found;
    logic [16:0] blocks_in_use;
    logic [16:0] file_blocks;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_MAP_RD,
    S_MAP_WAIT,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_MOVE2_WR,
    S_MAP_WR,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

### rtl/bcc_divider.sv
// Restoring divider for the group offset; one quotient bit per cycle.
// Depends on bcc_pkg.
module bcc_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [23:0]        dividend,
  input  logic [16:0]        divisor,
  output bcc_pkg::div_ctl_t  ctl,
  output logic [23:0]        quotient,
  output logic [16:0]        remainder
);
  import bcc_pkg::*;

  logic [4:0]  count;
  logic        busy;
  logic        done;
  logic [23:0] quo;
  logic [17:0] rem;
  logic [17:0] trial;

  assign trial = {rem[16:0], quo[23]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'd24;
        quo   <= dividend;
        rem   <= '0;
      end else if (busy) begin
        if (trial[17]) begin
          rem <= {rem[16:0], quo[23]};
          quo <= {quo[22:0], 1'b0};
        end else begin
          rem <= trial;
          quo <= {quo[22:0], 1'b1};
        end
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ctl.start  = start;
  assign ctl.busy   = busy;
  assign ctl.done   = done;
  assign quotient   = quo;
  assign remainder  = rem[16:0];

endmodule

### rtl/block_claim_checker.sv
// Top level of the block claim checker: sequencer, bitmap, duplicate table.
// Depends on bcc_pkg and bcc_divider.
//
// The block takes one command item when start is high and busy is low, and
// answers it with exactly one result item, shown for a single cycle with
// done high; the receiver cannot stall it, so capture the result on that
// cycle. A new inode or an out-of-range block is the quickest item; the
// others run the group division, one quotient bit per cycle through the
// divider, and some search the duplicate table one entry at a time through
// its single read port, a read state and a compare state for each entry.
// After reset the busy bitmap is cleared one bit per cycle; busy stays high
// and no item is accepted until that pass ends, though configuration writes
// are taken throughout.
module block_claim_checker #(
  parameter int MAX_BLOCKS      = 65536,
  parameter int DUP_TABLE_DEPTH = 64,
  parameter int DUP_LIMIT       = 10,
  parameter int BAD_LIMIT       = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bcc_pkg::in_item_t   item_in,
  output logic                busy,
  output logic                done,
  output bcc_pkg::out_item_t  item_out,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [16:0]         cfg_data
);
  import bcc_pkg::*;

  localparam int MW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int DW = $clog2(DUP_TABLE_DEPTH);
  localparam int CW = DW + 1;

  // Configuration registers.
  logic [15:0] first_group_block;
  logic [16:0] group_size;
  logic [15:0] group_inode_blocks;
  logic [16:0] group_count;
  logic [16:0] volume_blocks;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_group_block  <= '0;
      group_size         <= 17'd1;
      group_inode_blocks <= '0;
      group_count        <= '0;
      volume_blocks      <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FIRST_GROUP:  first_group_block  <= cfg_data[15:0];
        REG_GROUP_SIZE:   group_size         <= cfg_data;
        REG_GROUP_INODES: group_inode_blocks <= cfg_data[15:0];
        REG_GROUP_COUNT:  group_count        <= cfg_data;
        REG_VOLUME:       volume_blocks      <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // Item registers and counters.
  cmd_t        cmd;
  logic [23:0] blk;
  logic [CW-1:0] multi_end, dup_end;
  logic [7:0]  dup_cnt, bad_cnt;
  logic [16:0] file_cnt, used_cnt;
  logic [CW-1:0] idx;       // scan index into the duplicate table
  logic [CW-1:0] hit_idx;
  logic        hit;
  logic        map_bit;
  logic        rsv;
  logic [1:0]  st;
  logic        dup_f, bad_f;
  logic [MW-1:0] clr_addr;

  // Busy bitmap: one bit per block, single port, registered read.
  logic          map_mem [MAX_BLOCKS];
  logic          map_we, map_wd;
  logic [MW-1:0] map_addr;
  logic          map_rd;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_addr] <= map_wd;
    map_rd <= map_mem[map_addr];
  end

  // Duplicate table: one port, registered read. Entries below dup_end are in use.
  logic [MW-1:0] dup_mem [DUP_TABLE_DEPTH];
  logic          dt_we;
  logic [DW-1:0] dt_addr;
  logic [MW-1:0] dt_wd;
  logic [MW-1:0] dt_rd;

  always_ff @(posedge clk) begin
    if (dt_we) dup_mem[dt_addr] <= dt_wd;
    dt_rd <= dup_mem[dt_addr];
  end

  // Divider for the group test. It captures its dividend on the
  // accepting edge, so the offset is formed from the incoming block.
  logic        div_start;
  div_ctl_t    div_ctl;
  logic [23:0] quo;
  logic [16:0] rem;
  logic [23:0] offset;

  assign offset = item_in.block - {8'd0, first_group_block};

  bcc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (offset),
    .divisor   (group_size),
    .ctl       (div_ctl),
    .quotient  (quo),
    .remainder (rem)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  logic oor_now, below_first;
  assign oor_now     = ({7'd0, item_in.block} >= {14'd0, volume_blocks}) ||
                       ({8'd0, item_in.block} >= 32'(MAX_BLOCKS));
  assign below_first = (blk < {8'd0, first_group_block});

  logic [16:0] used_inc, used_dec, file_inc;
  logic [7:0]  dup_inc, bad_inc;
  assign used_inc = (used_cnt == '1) ? used_cnt : used_cnt + 17'd1;
  assign used_dec = (used_cnt == '0) ? used_cnt : used_cnt - 17'd1;
  assign file_inc = (file_cnt == '1) ? file_cnt : file_cnt + 17'd1;
  assign dup_inc  = (dup_cnt == 8'hFF) ? dup_cnt : dup_cnt + 8'd1;
  assign bad_inc  = (bad_cnt == 8'hFF) ? bad_cnt : bad_cnt + 8'd1;

  // Scan limit depends on the command: claim and rescan search the
  // distinct entries, release searches every entry below dup_end.
  logic [CW-1:0] scan_end;
  assign scan_end = (cmd == CMD_RELEASE) ? dup_end : multi_end;

  logic [CW-1:0] dup_end_m1, multi_end_m1;
  assign dup_end_m1   = dup_end - CW'(1);
  assign multi_end_m1 = multi_end - CW'(1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:
        if (accept) begin
          if (item_in.command == CMD_NEW_INODE) state_next = S_DONE;
          else if (oor_now) state_next = S_DONE;
          else state_next = S_DIV;
        end
      S_DIV:
        if (div_ctl.done || (!div_ctl.busy && !div_ctl.start)) state_next = S_MAP_RD;
      S_MAP_RD:   state_next = S_MAP_WAIT;
      S_MAP_WAIT: state_next = S_DECIDE;
      S_DECIDE:
        case (cmd)
          CMD_CLAIM:
            if (rsv) state_next = S_DONE;
            else if (!map_bit) state_next = S_MAP_WR;
            else if (dup_inc >= 8'(DUP_LIMIT) ||
                     dup_end >= CW'(DUP_TABLE_DEPTH)) state_next = S_DONE;
            else state_next = S_SCAN_RD;
          CMD_RESCAN: state_next = S_SCAN_RD;
          CMD_RELEASE:
            if (rsv || !map_bit) state_next = S_DONE;
            else state_next = S_SCAN_RD;
          default: state_next = S_DONE;
        endcase
      S_SCAN_RD:
        if (idx >= scan_end) state_next = (cmd == CMD_RELEASE) ? S_MAP_WR : S_MOVE_RD;
        else state_next = S_SCAN_CMP;
      S_SCAN_CMP:
        if (dt_rd == blk[MW-1:0]) state_next = S_MOVE_RD;
        else state_next = S_SCAN_RD;
      S_MOVE_RD: state_next = S_MOVE_WR;
      S_MOVE_WR:
        if (cmd == CMD_CLAIM && hit) state_next = S_DONE;
        else if (cmd == CMD_CLAIM) state_next = S_MOVE2_WR;
        else if (cmd == CMD_RESCAN && !hit) state_next = S_DONE;
        else if (cmd == CMD_RELEASE) state_next = S_DONE;
        else state_next = S_MOVE2_WR;
      S_MOVE2_WR: state_next = S_DONE;
      S_MAP_WR:   state_next = S_DONE;
      S_CLEAR:
        if (clr_addr == MW'(MAX_BLOCKS - 1)) state_next = S_IDLE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    map_we   = 1'b0;
    map_wd   = 1'b0;
    map_addr = blk[MW-1:0];
    dt_we    = 1'b0;
    dt_addr  = idx[DW-1:0];
    dt_wd    = blk[MW-1:0];
    div_start = 1'b0;
    case (state)
      S_IDLE:   div_start = accept && !oor_now && item_in.command != CMD_NEW_INODE &&
                            group_size != '0;
      S_CLEAR: begin
        map_we   = 1'b1;
        map_addr = clr_addr;
      end
      S_MAP_WR: begin
        map_we = 1'b1;
        map_wd = (cmd == CMD_CLAIM);
      end
      S_MOVE_RD: begin
        // Claim: read entry at multi_end (first copy). Rescan: last distinct.
        // Release: last entry.
        if (cmd == CMD_CLAIM) dt_addr = multi_end[DW-1:0];
        else if (cmd == CMD_RESCAN) dt_addr = multi_end_m1[DW-1:0];
        else dt_addr = dup_end_m1[DW-1:0];
      end
      S_MOVE_WR: begin
        if (cmd == CMD_CLAIM) begin
          dt_we   = 1'b1;
          dt_addr = dup_end[DW-1:0];
          dt_wd   = hit ? blk[MW-1:0] : dt_rd;
        end else if (cmd == CMD_RESCAN) begin
          dt_we   = hit;
          dt_addr = hit_idx[DW-1:0];
          dt_wd   = dt_rd;
        end else begin
          dt_we   = 1'b1;
          dt_addr = hit_idx[DW-1:0];
          dt_wd   = dt_rd;
        end
      end
      S_MOVE2_WR: begin
        // multi_end has already moved by one: a claim grew it, a rescan shrank it.
        dt_we   = 1'b1;
        dt_addr = (cmd == CMD_CLAIM) ? multi_end_m1[DW-1:0] : multi_end[DW-1:0];
        dt_wd   = blk[MW-1:0];
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      multi_end <= '0;
      dup_end   <= '0;
      dup_cnt   <= '0;
      bad_cnt   <= '0;
      file_cnt  <= '0;
      used_cnt  <= '0;
      hit       <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + MW'(1);
        S_IDLE:
          if (accept) begin
            cmd   <= cmd_t'(item_in.command);
            blk   <= item_in.block;
            st    <= ST_CONTINUE;
            dup_f <= 1'b0;
            bad_f <= 1'b0;
            idx   <= '0;
            hit   <= 1'b0;
            if (item_in.command == CMD_NEW_INODE) begin
              dup_cnt  <= '0;
              bad_cnt  <= '0;
              file_cnt <= '0;
            end else if (oor_now) begin
              if (item_in.command == CMD_CLAIM) begin
                bad_f   <= 1'b1;
                bad_cnt <= bad_inc;
                st <= (bad_inc >= 8'(BAD_LIMIT)) ? ST_STOP : ST_SKIP;
              end else begin
                st <= ST_SKIP;
              end
            end
          end
        S_MAP_WAIT: begin
          map_bit <= map_rd;
          rsv <= below_first || (group_size != '0 &&
                 rem < {1'b0, group_inode_blocks} && quo < {7'd0, group_count});
        end
        S_DECIDE:
          if (cmd == CMD_CLAIM) begin
            if (rsv) begin
              bad_f   <= 1'b1;
              bad_cnt <= bad_inc;
              st <= (bad_inc >= 8'(BAD_LIMIT)) ? ST_STOP : ST_SKIP;
            end else if (!map_bit) begin
              used_cnt <= used_inc;
              file_cnt <= file_inc;
            end else begin
              dup_f   <= 1'b1;
              dup_cnt <= dup_inc;
              if (dup_inc >= 8'(DUP_LIMIT) || dup_end >= CW'(DUP_TABLE_DEPTH))
                st <= ST_STOP;
            end
          end
        S_SCAN_CMP:
          if (dt_rd == blk[MW-1:0]) begin
            hit     <= 1'b1;
            hit_idx <= idx;
          end else begin
            idx <= idx + CW'(1);
          end
        S_MAP_WR:
          if (cmd == CMD_RELEASE) used_cnt <= used_dec;
        S_MOVE_WR: begin
          if (cmd == CMD_CLAIM) begin
            dup_end  <= dup_end + CW'(1);
            file_cnt <= file_inc;
            if (!hit) multi_end <= multi_end + CW'(1);
          end else if (cmd == CMD_RESCAN) begin
            if (hit) begin
              dup_f     <= 1'b1;
              multi_end <= multi_end_m1;
              if (multi_end_m1 == '0) st <= ST_STOP;
            end
          end else begin
            dup_end <= dup_end_m1;
            if (multi_end > dup_end_m1) multi_end <= dup_end_m1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output strobe and payload.
  always_comb begin
    done                   = (state == S_DONE);
    item_out.status        = st;
    item_out.dup_found     = dup_f;
    item_out.bad_found     = bad_f;
    item_out.blocks_in_use = used_cnt;
    item_out.file_blocks   = file_cnt;
  end

  // The copy region never shrinks below the distinct region.
  assert property (@(posedge clk) disable iff (rst) multi_end <= dup_end)
    else $error("multi_end passed dup_end");
  assert property (@(posedge clk) disable iff (rst)
    dup_end <= CW'(DUP_TABLE_DEPTH))
    else $error("duplicate table overfilled");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && accept) |=> busy)
    else $error("accepted item did not raise busy");

endmodule
